FILE: rtl/core/static_linked_list_engine_assert.svh
// Assertion macros for the static linked list engine.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef STATIC_LINKED_LIST_ENGINE_ASSERT_SVH
`define STATIC_LINKED_LIST_ENGINE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SLE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SLE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/sle_pkg.sv
// Shared constants, codes and control structs for the static linked list engine.
// No dependencies.
package sle_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY + 1);
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int DATA_W   = 32;
   localparam int OP_W     = 3;

   typedef logic [IDX_W-1:0] idx_type;

   // Null link; anything at or above it is treated as null.
   localparam idx_type NIL = idx_type'(CAPACITY);

   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
   localparam logic [OP_W-1:0] OP_APPEND  = 3'd1;
   localparam logic [OP_W-1:0] OP_ROTATE  = 3'd2;
   localparam logic [OP_W-1:0] OP_REVERSE = 3'd3;
   localparam logic [OP_W-1:0] OP_DUMP    = 3'd4;

   // Link memory read address source
   localparam logic [1:0] RD_FREE = 2'd0;
   localparam logic [1:0] RD_HEAD = 2'd1;
   localparam logic [1:0] RD_NEXT = 2'd2;

   // Link memory write address source
   localparam logic [1:0] WA_NODE = 2'd0;
   localparam logic [1:0] WA_CUR  = 2'd1;
   localparam logic [1:0] WA_HEAD = 2'd2;

   // Link memory write data source
   localparam logic [1:0] WD_NIL  = 2'd0;
   localparam logic [1:0] WD_NODE = 2'd1;
   localparam logic [1:0] WD_HEAD = 2'd2;
   localparam logic [1:0] WD_PREV = 2'd3;

   typedef struct packed {
      logic       clear;
      logic       take;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       wr_en;
      logic [1:0] wa_sel;
      logic [1:0] wd_sel;
      logic       val_wr;
      logic       node_ld;
      logic       node_from_nx;
      logic       free_ld;
      logic       head_ld;
      logic       head_from_cur;
      logic       cur_ld;
      logic       cur_from_nx;
      logic       prev_clr;
      logic       prev_ld;
      logic       emit;
      logic       emit_ok;
      logic       emit_elem;
      logic       emit_last_nx;
   } cmd_type;

   typedef struct packed {
      logic free_null;
      logic head_null;
      logic nx_null;
      logic out_free;
   } status_type;

endpackage

FILE: rtl/core/sle_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on sle_pkg.
interface sle_req_if;
   import sle_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          operation;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface

interface sle_rsp_if;
   import sle_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     ok;
   logic signed [DATA_W-1:0] element;
   logic                     last;

   modport source (output valid, output ok, output element, output last, input ready);
   modport sink   (input valid, input ok, input element, input last, output ready);
endinterface

FILE: rtl/core/sle_ctrl.sv
// Sequencer for the static linked list engine: decodes operations and steps
// the datapath through list walks. Depends on sle_pkg.
module sle_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [sle_pkg::OP_W-1:0]  req_operation,
   output logic                      req_ready,
   input  sle_pkg::status_type       status,
   output sle_pkg::cmd_type          cmd
);
   import sle_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_APP  = 4'd1;
   localparam logic [3:0] S_WALK = 4'd2;
   localparam logic [3:0] S_ROT1 = 4'd3;
   localparam logic [3:0] S_ROTW = 4'd4;
   localparam logic [3:0] S_ROTF = 4'd5;
   localparam logic [3:0] S_REV  = 4'd6;
   localparam logic [3:0] S_DUMP = 4'd7;
   localparam logic [3:0] S_OK   = 4'd8;
   localparam logic [3:0] S_FAIL = 4'd9;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               case (req_operation)
                  OP_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  OP_APPEND: begin
                     if (status.free_null) begin
                        state_in = S_FAIL;
                     end else begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = RD_FREE;
                        cmd.node_ld = 1'b1;
                        state_in    = S_APP;
                     end
                  end
                  OP_ROTATE: begin
                     if (!status.head_null) begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_HEAD;
                        state_in   = S_ROT1;
                     end
                  end
                  OP_REVERSE: begin
                     if (!status.head_null) begin
                        cmd.rd_en    = 1'b1;
                        cmd.rd_sel   = RD_HEAD;
                        cmd.cur_ld   = 1'b1;
                        cmd.prev_clr = 1'b1;
                        state_in     = S_REV;
                     end
                  end
                  OP_DUMP: begin
                     if (status.head_null) begin
                        state_in = S_FAIL;
                     end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_HEAD;
                        state_in   = S_DUMP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_APP: begin
            // new node is detached; free list advances past it
            cmd.free_ld = 1'b1;
            cmd.val_wr  = 1'b1;
            cmd.wr_en   = 1'b1;
            cmd.wa_sel  = WA_NODE;
            cmd.wd_sel  = WD_NIL;
            if (status.head_null) begin
               cmd.head_ld = 1'b1;
               state_in    = S_OK;
            end else begin
               cmd.cur_ld = 1'b1;
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_HEAD;
               state_in   = S_WALK;
            end
         end
         S_WALK: begin
            if (status.nx_null) begin
               cmd.wr_en  = 1'b1;
               cmd.wa_sel = WA_CUR;
               cmd.wd_sel = WD_NODE;
               state_in   = S_OK;
            end else begin
               cmd.cur_ld      = 1'b1;
               cmd.cur_from_nx = 1'b1;
               cmd.rd_en       = 1'b1;
               cmd.rd_sel      = RD_NEXT;
            end
         end
         S_ROT1: begin
            if (status.nx_null) begin
               state_in = S_IDLE;
            end else begin
               // remember the second node as the new head
               cmd.node_ld      = 1'b1;
               cmd.node_from_nx = 1'b1;
               cmd.cur_ld       = 1'b1;
               cmd.cur_from_nx  = 1'b1;
               cmd.rd_en        = 1'b1;
               cmd.rd_sel       = RD_NEXT;
               state_in         = S_ROTW;
            end
         end
         S_ROTW: begin
            if (status.nx_null) begin
               cmd.wr_en  = 1'b1;
               cmd.wa_sel = WA_CUR;
               cmd.wd_sel = WD_HEAD;
               state_in   = S_ROTF;
            end else begin
               cmd.cur_ld      = 1'b1;
               cmd.cur_from_nx = 1'b1;
               cmd.rd_en       = 1'b1;
               cmd.rd_sel      = RD_NEXT;
            end
         end
         S_ROTF: begin
            cmd.wr_en   = 1'b1;
            cmd.wa_sel  = WA_HEAD;
            cmd.wd_sel  = WD_NIL;
            cmd.head_ld = 1'b1;
            state_in    = S_IDLE;
         end
         S_REV: begin
            cmd.wr_en   = 1'b1;
            cmd.wa_sel  = WA_CUR;
            cmd.wd_sel  = WD_PREV;
            cmd.prev_ld = 1'b1;
            if (status.nx_null) begin
               cmd.head_ld       = 1'b1;
               cmd.head_from_cur = 1'b1;
               state_in          = S_IDLE;
            end else begin
               cmd.cur_ld      = 1'b1;
               cmd.cur_from_nx = 1'b1;
               cmd.rd_en       = 1'b1;
               cmd.rd_sel      = RD_NEXT;
            end
         end
         S_DUMP: begin
            if (status.out_free) begin
               cmd.emit         = 1'b1;
               cmd.emit_ok      = 1'b1;
               cmd.emit_elem    = 1'b1;
               cmd.emit_last_nx = 1'b1;
               if (status.nx_null) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_NEXT;
               end
            end
         end
         S_OK: begin
            if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.emit_ok = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_FAIL: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/sle_dp.sv
// Datapath for the static linked list engine: link and value memories,
// list pointers and the response register. Depends on sle_pkg, sle_rsp_if.
module sle_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic signed [sle_pkg::DATA_W-1:0] req_value,
   input  sle_pkg::cmd_type                cmd,
   output sle_pkg::status_type             status,
   sle_rsp_if.source                       rsp
);
   import sle_pkg::*;

   logic [IDX_W-1:0]  next_mem  [CAPACITY];
   logic [DATA_W-1:0] value_mem [CAPACITY];

   // entry not yet written since clear reads as its free-chain default
   logic [CAPACITY-1:0] valid_ff, valid_in;

   idx_type head_ff, head_in, free_ff, free_in;
   idx_type node_ff, cur_ff, prev_ff;
   logic signed [DATA_W-1:0] value_ff;

   idx_type           next_rd_ff;
   logic [DATA_W-1:0] value_rd_ff;
   logic              rd_valid_ff;
   logic [ADDR_W-1:0] rd_addr_ff;

   idx_type           nx, nx_dflt, rd_idx, wr_idx, wr_data;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic              nx_null, out_free;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_ok_ff, rsp_last_ff;
   logic signed [DATA_W-1:0] rsp_element_ff;

   // link read back, with the unwritten-entry default substituted
   assign nx_dflt = (rd_addr_ff == ADDR_W'(CAPACITY - 1)) ? NIL
                  : idx_type'(rd_addr_ff) + idx_type'(1);
   assign nx      = rd_valid_ff ? next_rd_ff : nx_dflt;
   assign nx_null = (nx >= NIL);

   always_comb begin
      case (cmd.rd_sel)
         RD_FREE: rd_idx = free_ff;
         RD_HEAD: rd_idx = head_ff;
         RD_NEXT: rd_idx = nx;
         default: rd_idx = head_ff;
      endcase
      case (cmd.wa_sel)
         WA_NODE: wr_idx = node_ff;
         WA_CUR:  wr_idx = cur_ff;
         WA_HEAD: wr_idx = head_ff;
         default: wr_idx = cur_ff;
      endcase
      case (cmd.wd_sel)
         WD_NIL:  wr_data = NIL;
         WD_NODE: wr_data = node_ff;
         WD_HEAD: wr_data = head_ff;
         WD_PREV: wr_data = prev_ff;
         default: wr_data = NIL;
      endcase
   end

   assign rd_addr = rd_idx[ADDR_W-1:0];
   assign wr_addr = wr_idx[ADDR_W-1:0];

   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = '0;
      end else if (cmd.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_comb begin
      head_in = head_ff;
      free_in = free_ff;
      if (cmd.clear) begin
         head_in = NIL;
         free_in = '0;
      end else begin
         if (cmd.head_ld) begin
            head_in = cmd.head_from_cur ? cur_ff : node_ff;
         end
         if (cmd.free_ld) begin
            free_in = nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         head_ff  <= NIL;
         free_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         head_ff  <= head_in;
         free_ff  <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         value_ff <= req_value;
      end
      if (cmd.node_ld) begin
         node_ff <= cmd.node_from_nx ? nx : free_ff;
      end
      if (cmd.cur_ld) begin
         cur_ff <= cmd.cur_from_nx ? nx : head_ff;
      end
      if (cmd.prev_clr) begin
         prev_ff <= NIL;
      end else if (cmd.prev_ld) begin
         prev_ff <= cur_ff;
      end
   end

   // memories: one write and one registered read per cycle each
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         next_mem[wr_addr] <= wr_data;
      end
      if (cmd.val_wr) begin
         value_mem[node_ff[ADDR_W-1:0]] <= value_ff;
      end
      if (cmd.rd_en) begin
         next_rd_ff  <= next_mem[rd_addr];
         value_rd_ff <= value_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         rd_addr_ff  <= rd_addr;
      end
   end

   // response register
   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ok_ff      <= cmd.emit_ok;
         rsp_element_ff <= cmd.emit_elem ? value_rd_ff : '0;
         rsp_last_ff    <= cmd.emit_last_nx ? nx_null : 1'b1;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.ok      = rsp_ok_ff;
   assign rsp.element = rsp_element_ff;
   assign rsp.last    = rsp_last_ff;

   assign status.free_null = (free_ff >= NIL);
   assign status.head_null = (head_ff >= NIL);
   assign status.nx_null   = nx_null;
   assign status.out_free  = out_free;

endmodule

FILE: rtl/core/static_linked_list_engine.sv
// Static linked list engine: a pool of CAPACITY nodes (value plus next link)
// with a free list. req_bus carries one operation per beat (clear, append,
// rotate, reverse, dump) with an append value; rsp_bus returns ok, element
// and last. Append returns one beat (ok low when the pool is full), dump one
// beat per node in list order (one ok-low beat if empty), others none.
// req_bus.ready is high only while no operation is in progress; one at a time.
// Walks read one link per cycle; a dump walk, which also returns one beat
// per cycle, does so only while rsp_bus is not stalled.
// The response sits in an output register, so the next request is taken
// while the last beat of the previous one still waits.
// A stall on rsp_bus pauses a dump walk in place; nothing is dropped.
// Reset (synchronous, active high) empties the list and rebuilds the free
// chain through per-entry written flags; no clearing pass.
// Depends on sle_pkg, sle_if, sle_ctrl, sle_dp and the assertion macros.
`include "static_linked_list_engine_assert.svh"

module static_linked_list_engine (
   input logic       clock,
   input logic       reset,
   sle_req_if.sink   req_bus,
   sle_rsp_if.source rsp_bus
);
   import sle_pkg::*;

   cmd_type    cmd;
   status_type status;

   sle_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_operation (req_bus.operation),
      .req_ready     (req_bus.ready),
      .status        (status),
      .cmd           (cmd)
   );

   sle_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_value (req_bus.value),
      .cmd       (cmd),
      .status    (status),
      .rsp       (rsp_bus)
   );

   `SLE_ASSERT_NOW(a_clear_on_beat, cmd.clear, req_bus.valid && req_bus.ready,
                   "clear without request beat")
   `SLE_ASSERT_NOW(a_walk_not_null, cmd.rd_en && (cmd.rd_sel == RD_NEXT),
                   !status.nx_null, "link read past list end")
   `SLE_ASSERT_NOW(a_emit_has_room, cmd.emit, status.out_free, "response overwritten")
   `SLE_ASSERT_NEXT(a_clear_state,
                    req_bus.valid && req_bus.ready && (req_bus.operation == OP_CLEAR),
                    status.head_null && !status.free_null,
                    "clear left list or free chain wrong")

endmodule
